// ===== rtl/wde_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wde_pkg: shared functions of the Whirlpool engine
// S-box, circulant row table, round constants and the rho function.
// ---------------------------------------------------------------------------
package wde_pkg;

  localparam logic [63:0] RC0 = 64'h1823c6e887b8014f;

  function automatic logic [3:0] mini_e(input logic [3:0] x);
    logic [63:0] t;
    t = 64'h1B9CD6F3E874A250;
    return t[63 - 4*x -: 4];
  endfunction

  function automatic logic [3:0] mini_r(input logic [3:0] x);
    logic [63:0] t;
    t = 64'h7CBDE49F638A2510;
    return t[63 - 4*x -: 4];
  endfunction

  function automatic logic [3:0] einv(input logic [3:0] x);
    logic [3:0] r;
    r = 4'd0;
    for (int u = 0; u < 16; u++) begin
      if (mini_e(4'(u)) == x) r = 4'(u);
    end
    return r;
  endfunction

  function automatic logic [7:0] sbox(input logic [7:0] u);
    logic [3:0] a;
    logic [3:0] b;
    logic [3:0] r;
    a = mini_e(u[7:4]);
    b = einv(u[3:0]);
    r = mini_r(a ^ b);
    return {mini_e(a ^ r), einv(b ^ r)};
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1d : 8'h00);
  endfunction

  // S-box lookup followed by the circulant (1,1,4,1,8,5,2,9)
  function automatic logic [63:0] lane0(input logic [7:0] u);
    logic [7:0] s1;
    logic [7:0] s2;
    logic [7:0] s4;
    logic [7:0] s8;
    s1 = sbox(u);
    s2 = xt(s1);
    s4 = xt(s2);
    s8 = xt(s4);
    return {s1, s1, s4, s1, s8, s4 ^ s1, s2, s8 ^ s1};
  endfunction

  function automatic logic [63:0] round_const(input logic [3:0] r);
    logic [63:0] v;
    v = '0;
    for (int j = 0; j < 8; j++) begin
      v = {v[55:0], sbox(8'(8 * r + j))};
    end
    return v;
  endfunction

  function automatic logic [63:0] rotr(input logic [63:0] c, input int t);
    return (c >> (8 * t)) | (c << (64 - 8 * t));
  endfunction

  // one output row of rho; x holds rows 0..7, row 0 in the low bits
  function automatic logic [63:0] rho_row(input logic [511:0] x, input logic [2:0] i);
    logic [63:0] acc;
    logic [63:0] c;
    logic [2:0] k;
    acc = '0;
    for (int t = 0; t < 8; t++) begin
      k = i - 3'(t);
      c = lane0(x[64*k + 56 - 8*t +: 8]);
      if (t != 0) c = rotr(c, t);
      acc = acc ^ c;
    end
    return acc;
  endfunction

  function automatic logic [511:0] rho(input logic [511:0] x);
    logic [511:0] y;
    for (int i = 0; i < 8; i++) y[64*i +: 64] = rho_row(x, 3'(i));
    return y;
  endfunction

endpackage

// ===== rtl/wde_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wde_ram: generic simple dual-port RAM (separate write and read address)
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
module wde_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/whirlpool_digest_engine_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// whirlpool_digest_engine_top: Whirlpool-512 digest engine
// Collects message words into 64-byte blocks held in a block RAM,
// compresses each block one round per cycle, pads and emits the digest.
// ---------------------------------------------------------------------------
// channel | dir | tdata                          | tuser             | tlast
// s_axis  | in  | [63:0] message_word            | [3:0] bytes_valid | message_end
// m_axis  | out | [63:0] digest_word             | -                 | digest_last
//
// Flow: a beat is accepted, its bytes are placed one byte per cycle (held while
// a full block is compressed), then a closing step follows. Every 64 bytes a
// compression runs block RAM reads, the ROUNDS rounds and a feedback step.
// A message end writes padding one byte per cycle up to the block end, for
// one or two blocks each followed by a compression, then 8 digest beats.
// Reset (rst, synchronous) clears counters and the chaining value.
// s_axis_tready is high only when idle; m_axis holds its beat until taken.
// ---------------------------------------------------------------------------
module whirlpool_digest_engine_top #(
  parameter int ROUNDS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [63:0] message_word
  input  logic [3:0]  s_axis_tuser,   // [3:0] bytes_valid
  input  logic        s_axis_tlast,   // message_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [63:0] digest_word
  output logic        m_axis_tlast    // digest_last
);

  localparam logic [2:0] S_IN   = 3'd0;  // take bytes from the held word
  localparam logic [2:0] S_LOAD = 3'd1;  // read block rows from RAM
  localparam logic [2:0] S_RND  = 3'd2;
  localparam logic [2:0] S_FB   = 3'd3;
  localparam logic [2:0] S_PAD  = 3'd4;  // write padding bytes
  localparam logic [2:0] S_OUT  = 3'd5;
  localparam logic [2:0] S_IDLE = 3'd6;

  logic [2:0]   state;
  logic [63:0]  word;         // held input bytes, next byte at top
  logic [3:0]   left;         // bytes still to place
  logic         is_end;
  logic [6:0]   fill;
  logic [60:0]  blocks;
  logic [63:0]  bitlen;
  logic         pad_phase;    // 0: padded block without length, 1: length block
  logic         final_blk;
  logic [3:0]   cnt;
  logic [511:0] hv, kv, sv, mv;

  // block buffer: 8 rows of 64 bits with a byte written by read-modify-write
  // avoided: bytes go to a row register and whole rows are written
  logic [63:0]  rowbuf;
  logic         ram_we;
  logic [2:0]   ram_waddr, ram_raddr;
  logic [63:0]  ram_wdata, ram_rdata;
  logic         rd_valid;
  logic [2:0]   rd_row;

  wde_ram #(.WIDTH(64), .DEPTH(8)) u_blk (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  logic [63:0]  row_new;
  logic [2:0]   bpos;
  logic [6:0]   fill_inc;
  assign bpos = fill[2:0];
  assign fill_inc = fill + 7'd1;
  always_comb begin
    row_new = rowbuf;
    row_new[63 - 8*bpos -: 8] = word[63:56];
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = fill[5:3];
    ram_wdata = row_new;
    if (state == S_IN && left != 4'd0 && bpos == 3'd7) ram_we = 1'b1;
    if (state == S_PAD && bpos == 3'd7) ram_we = 1'b1;
  end
  assign ram_raddr = cnt[2:0];

  // byte for the next padding position: length bytes in the last row
  logic [63:0] pad_byte_word;
  always_comb begin
    pad_byte_word = 64'd0;
    if (pad_phase && fill_inc[5:3] == 3'd7)
      pad_byte_word[63:56] = bitlen[63 - 8*fill_inc[2:0] -: 8];
  end

  assign s_axis_tready = (state == S_IDLE);

  logic [511:0] k_next;
  assign k_next = wde_pkg::rho(kv) ^
                  {448'd0, (cnt < 4'd10) ? wde_pkg::round_const(cnt) : 64'd0};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; fill <= '0; blocks <= '0; hv <= '0; cnt <= '0;
      m_axis_tvalid <= 1'b0; rd_valid <= 1'b0; left <= '0; is_end <= 1'b0;
      pad_phase <= 1'b0; final_blk <= 1'b0;
    end else begin
      rd_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            word   <= s_axis_tdata;
            left   <= (s_axis_tuser > 4'd8) ? 4'd8 : s_axis_tuser;
            is_end <= s_axis_tlast;
            state  <= S_IN;
          end
        end
        S_IN: begin
          if (left != 4'd0) begin
            rowbuf <= (bpos == 3'd7) ? 64'd0 : row_new;
            word <= {word[55:0], 8'd0};
            left <= left - 4'd1;
            if (fill == 7'd63) begin
              fill <= '0; blocks <= blocks + 61'd1; final_blk <= 1'b0;
              cnt <= '0; state <= S_LOAD;
            end else fill <= fill + 7'd1;
          end else if (is_end) begin
            // 0x80 lands at fill; the length fits here only below 32 bytes
            bitlen <= {blocks[54:0], 9'd0} + {54'd0, fill, 3'd0};
            word <= 64'h80 << 56; pad_phase <= ~fill[5]; final_blk <= 1'b1;
            state <= S_PAD;
          end else state <= S_IDLE;
        end
        S_PAD: begin
          // 0x80 (first padded block only), then zeros; in the length block the length bytes land in the last row
          rowbuf <= (bpos == 3'd7) ? 64'd0 : row_new;
          word <= pad_byte_word;
          if (fill == 7'd63) begin
            fill <= '0; cnt <= '0; state <= S_LOAD;
          end else fill <= fill_inc;
        end
        S_LOAD: begin
          cnt <= cnt + 4'd1;
          if (cnt != 4'd8) begin rd_valid <= 1'b1; rd_row <= cnt[2:0]; end
          if (rd_valid) begin
            mv[64*rd_row +: 64] <= ram_rdata;
            kv[64*rd_row +: 64] <= hv[64*rd_row +: 64];
            sv[64*rd_row +: 64] <= ram_rdata ^ hv[64*rd_row +: 64];
          end
          if (cnt == 4'd8) begin cnt <= '0; state <= S_RND; end
        end
        S_RND: begin
          kv <= k_next;
          sv <= wde_pkg::rho(sv) ^ k_next;
          cnt <= cnt + 4'd1;
          if (cnt == 4'(ROUNDS - 1)) state <= S_FB;
        end
        S_FB: begin
          hv <= hv ^ sv ^ mv; cnt <= '0;
          if (!final_blk) state <= S_IN;
          else if (pad_phase) begin
            state <= S_OUT; m_axis_tvalid <= 1'b1;
            m_axis_tdata <= hv[63:0] ^ sv[63:0] ^ mv[63:0];
          end else begin
            // extra block: zeros then the length
            pad_phase <= 1'b1; word <= 64'd0; state <= S_PAD;
          end
        end
        S_OUT: begin
          if (m_axis_tready) begin
            if (cnt == 4'd7) begin
              m_axis_tvalid <= 1'b0; hv <= '0; fill <= '0; blocks <= '0;
              final_blk <= 1'b0; state <= S_IDLE;
            end else begin
              cnt <= cnt + 4'd1;
              m_axis_tdata <= hv[64*(cnt[2:0]+3'd1) +: 64];
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
  assign m_axis_tlast = (cnt == 4'd7);

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: testbench of the Whirlpool digest engine
// Sends message words on s_axis, hashes the same bytes with a local
// Whirlpool model and checks every digest beat on m_axis in order.
// ---------------------------------------------------------------------------
module tb;

  localparam int RND = 10;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;   // [63:0] message_word
  logic [3:0]  s_axis_tuser;   // [3:0] bytes_valid
  logic        s_axis_tlast;   // message_end
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;   // [63:0] digest_word
  logic        m_axis_tlast;   // digest_last

  whirlpool_digest_engine_top #(.ROUNDS(RND)) dut (.*);

  typedef struct packed {
    logic [63:0] word;
    logic        last;
  } digest_beat_t;

  // local hash state
  logic [63:0] hv [8];
  logic [7:0]  blk [64];
  int          nfill;
  logic [60:0] nblocks;
  logic [63:0] sbox_lane [256];
  logic [63:0] rconst [10];

  digest_beat_t digest_q[$];
  bit  failed;
  bit  idle_on;
  longint cycles;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // tables built from the S-box definition: E, R mini-boxes, circulant rows
  function automatic logic [7:0] gmul(logic [7:0] a, int m);
    logic [8:0] v;
    logic [7:0] acc;
    v = {1'b0, a};
    acc = 0;
    while (m != 0) begin
      if (m & 1) acc ^= v[7:0];
      v = v << 1;
      if (v[8]) v ^= 9'h11d;
      m >>= 1;
    end
    return acc;
  endfunction

  task automatic build_tables();
    logic [3:0] e [16];
    logic [3:0] r [16];
    logic [3:0] ei [16];
    logic [7:0] sb [256];
    int coef [8];
    logic [63:0] e_bits, r_bits, v;
    logic [3:0] a, b, q;
    e_bits = 64'h1B9CD6F3E874A250;
    r_bits = 64'h7CBDE49F638A2510;
    coef = '{1, 1, 4, 1, 8, 5, 2, 9};
    for (int u = 0; u < 16; u++) begin
      e[u] = e_bits[63 - 4*u -: 4];
      r[u] = r_bits[63 - 4*u -: 4];
    end
    for (int u = 0; u < 16; u++) ei[e[u]] = 4'(u);
    for (int u = 0; u < 256; u++) begin
      a = e[u >> 4];
      b = ei[u & 15];
      q = r[a ^ b];
      sb[u] = {e[a ^ q], ei[b ^ q]};
    end
    for (int u = 0; u < 256; u++) begin
      v = 0;
      for (int j = 0; j < 8; j++) v = {v[55:0], gmul(sb[u], coef[j])};
      sbox_lane[u] = v;
    end
    for (int u = 0; u < 10; u++) begin
      v = 0;
      for (int j = 0; j < 8; j++) v = {v[55:0], sb[8*u + j]};
      rconst[u] = v;
    end
  endtask

  function automatic void mix_layer(input logic [63:0] x [8], output logic [63:0] y [8]);
    logic [63:0] acc, c;
    for (int i = 0; i < 8; i++) begin
      acc = 0;
      for (int t = 0; t < 8; t++) begin
        c = sbox_lane[x[(i + 8 - t) % 8][56 - 8*t +: 8]];
        if (t != 0) c = (c >> (8*t)) | (c << (64 - 8*t));
        acc ^= c;
      end
      y[i] = acc;
    end
  endfunction

  task automatic compress_block();
    logic [63:0] msg [8];
    logic [63:0] key [8];
    logic [63:0] st [8];
    logic [63:0] tmp [8];
    for (int i = 0; i < 8; i++) begin
      msg[i] = 0;
      for (int j = 0; j < 8; j++) msg[i] = {msg[i][55:0], blk[8*i + j]};
      key[i] = hv[i];
      st[i]  = msg[i] ^ hv[i];
    end
    for (int r = 0; r < RND; r++) begin
      mix_layer(key, tmp);
      tmp[0] ^= rconst[r];
      key = tmp;
      mix_layer(st, tmp);
      for (int i = 0; i < 8; i++) st[i] = tmp[i] ^ key[i];
    end
    for (int i = 0; i < 8; i++) hv[i] ^= st[i] ^ msg[i];
  endtask

  // absorbs one beat and queues the digest on a message end
  task automatic absorb_word(logic [63:0] w, logic [3:0] nb, logic fin);
    int cnt;
    logic [63:0] bitlen;
    digest_beat_t d;
    cnt = (nb > 8) ? 8 : nb;
    for (int i = 0; i < cnt; i++) begin
      blk[nfill] = w[63 - 8*i -: 8];
      nfill++;
      if (nfill == 64) begin
        compress_block();
        nfill = 0;
        nblocks++;
      end
    end
    if (!fin) return;
    bitlen = {nblocks[54:0], 9'd0} + 64'(nfill * 8);
    blk[nfill] = 8'h80;
    nfill++;
    if (nfill > 32) begin
      for (int i = nfill; i < 64; i++) blk[i] = 0;
      compress_block();
      nfill = 0;
    end
    for (int i = nfill; i < 56; i++) blk[i] = 0;
    for (int i = 0; i < 8; i++) blk[56 + i] = bitlen[63 - 8*i -: 8];
    compress_block();
    for (int i = 0; i < 8; i++) begin
      d.word = hv[i];
      d.last = (i == 7);
      digest_q.push_back(d);
      hv[i] = 0;
    end
    nfill = 0;
    nblocks = 0;
  endtask

  task automatic send_word(logic [63:0] w, logic [3:0] nb, logic fin);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= w;
    s_axis_tuser  <= nb;
    s_axis_tlast  <= fin;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    absorb_word(w, nb, fin);
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  // digest beat checker
  always @(posedge clk) begin
    digest_beat_t e;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (digest_q.size() == 0) begin
        $display("%0t: unexpected digest beat %h last %b", $time, m_axis_tdata,
                 m_axis_tlast);
        failed = 1;
      end else begin
        e = digest_q.pop_front();
        if (e.word !== m_axis_tdata || e.last !== m_axis_tlast) begin
          $display("%0t: digest mismatch exp %h/%b got %h/%b", $time, e.word, e.last,
                   m_axis_tdata, m_axis_tlast);
          failed = 1;
        end
      end
    end
  end

  // receiver stall bursts
  initial begin
    int n;
    m_axis_tready = 0;
    @(negedge rst);
    forever begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 5);
        m_axis_tready <= 0;
        repeat (n) @(posedge clk);
      end
      m_axis_tready <= 1;
      @(posedge clk);
    end
  end

  // watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 400000) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // empty message, one byte, full-byte extremes, 31/32/55/56/63/64 byte
  // boundaries, oversize byte counts and a short word mid-stream
  task automatic test_directed();
    int lens [8];
    lens = '{0, 1, 31, 32, 55, 56, 63, 64};
    send_word(64'h0, 4'd0, 1);
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 0);
    send_word(64'h0, 4'd8, 1);
    send_word(64'hA5A5_5A5A_0F0F_F0F0, 4'd15, 0);
    send_word(64'h1234_5678_9ABC_DEF0, 4'd3, 0);
    send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd9, 1);
    for (int k = 0; k < 8; k++) begin
      for (int b = lens[k]; b > 0; b -= 8)
        send_word(64'h6162_6364_6566_6768, 4'((b >= 8) ? 8 : b), 0);
      send_word(64'h0, 4'd0, 1);
    end
  endtask

  // random messages of mixed length and word shapes
  task automatic test_random(int nwords);
    int left, mlen;
    logic [3:0] nb;
    left = nwords;
    while (left > 0) begin
      mlen = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 6);
      for (int i = 0; i < mlen; i++) begin
        case ($urandom_range(0, 9))
          0:       nb = 4'($urandom_range(0, 15));
          1:       nb = 4'($urandom_range(0, 7));
          default: nb = 4'd8;
        endcase
        send_word(rnd64(), nb, i == mlen - 1);
        left--;
      end
    end
  endtask

  initial begin
    build_tables();
    for (int i = 0; i < 8; i++) hv[i] = 0;
    nfill = 0;
    nblocks = 0;
    failed = 0;
    idle_on = 1;
    rst = 1;
    s_axis_tvalid = 0;
    s_axis_tdata = 0;
    s_axis_tuser = 0;
    s_axis_tlast = 0;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_random(170);
    idle_on = 0;
    test_random(50);
    s_axis_tvalid <= 0;
    while (digest_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (!failed) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/wde_pkg.sv
rtl/wde_ram.sv
rtl/whirlpool_digest_engine_top.sv
tb/sv/tb.sv
